>>> sv/base58_encoder_defines.svh
// Assertion macros for the base58 encoder RTL.
// Included by files that carry assertions; define NO_ASSERTIONS to drop them.
`ifndef BASE58_ENCODER_DEFINES_SVH
`define BASE58_ENCODER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Plain property, checked every clock outside reset.
`define B58_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define B58_ASSERT_IMP(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

`else

`define B58_ASSERT(label, clk, rst_n, prop, msg)
`define B58_ASSERT_IMP(label, clk, rst_n, cond, expr, msg)

`endif

`endif

>>> sv/b58enc_pkg.sv
// Shared types, constants and helpers for the base58 encoder.
// No dependencies; imported by the top level, the sequencer and the datapath.
package b58enc_pkg;

    localparam int MAX_IN_BYTES = 32;
    localparam int MAX_DIGITS   = 48;

    localparam int BASE       = 58;
    localparam int DIGIT_W    = 6;
    localparam int CHAR_W     = 8;
    localparam int CAP_W      = 7;
    localparam int CAP_RESET  = 64;
    localparam int ADDR_W     = $clog2(MAX_DIGITS);
    localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
    localparam int BYTE_CNT_W = $clog2(MAX_IN_BYTES + 1);
    localparam int CMP_W      = 8;

    // digit*256 + carry = BASE*(HI_Q*digit) + (HI_MULT*digit + carry)
    localparam int HI_Q      = 256 / BASE;
    localparam int HI_MULT   = 256 % BASE;
    localparam int QUOT_W    = 8;
    localparam int Y_W       = 11;
    localparam int QY_W      = 5;
    // floor(2^15/58) underestimates 1/58 by less than one step for y < 2^11
    localparam int RECIP_SH  = 15;
    localparam int RECIP     = (1 << RECIP_SH) / BASE;
    localparam int PROD_W    = Y_W + 10;

    localparam logic [BASE*CHAR_W-1:0] B58_ALPHABET =
        "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";
    localparam logic [CHAR_W-1:0] ONE_CHAR = "1";

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last_char;
        logic       encode_error;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ABSORB,
        ST_WALK,
        ST_APPEND,
        ST_FINISH,
        ST_ONES,
        ST_DIGITS_RD,
        ST_DIGITS,
        ST_ERROR,
        ST_CLEAR
    } state_t;

    typedef struct packed {
        logic take_item;
        logic set_ovf;
        logic byte_inc;
        logic ones_inc;
        logic set_nz;
        logic walk_first;
        logic walk_step;
        logic append;
        logic emit_one;
        logic emit_digit;
        logic emit_error;
        logic clear;
    } cmd_t;

    typedef struct packed {
        logic overflow;
        logic bytes_full;
        logic lead_zero;
        logic room_full;
        logic digits_full;
        logic no_digits;
        logic walk_end;
        logic carry_zero;
        logic last;
        logic no_ones;
        logic ones_one;
        logic digits_one;
        logic out_free;
    } status_t;

    function automatic logic [CHAR_W-1:0] b58_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        c = '0;
        if (int'(d) < BASE)
        begin
            c = B58_ALPHABET[(BASE - 1 - int'(d))*CHAR_W +: CHAR_W];
        end
        return c;
    endfunction

endpackage

>>> sv/b58enc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module b58enc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> sv/b58enc_ctrl.sv
// Sequencer for the base58 encoder: absorb, digit walk, append, emit.
// Depends on b58enc_pkg and base58_encoder_defines.svh.
`include "base58_encoder_defines.svh"

module b58enc_ctrl
    import b58enc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_ABSORB;
                end
            end
            ST_ABSORB:
            begin
                if (status.overflow || status.bytes_full || status.lead_zero)
                begin
                    state_next = ST_FINISH;
                end
                else if (status.no_digits)
                begin
                    state_next = ST_APPEND;
                end
                else
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (status.walk_end)
                begin
                    state_next = ST_APPEND;
                end
            end
            ST_APPEND:
            begin
                if (status.carry_zero || status.room_full || status.digits_full)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!status.last)
                begin
                    state_next = ST_IDLE;
                end
                else if (status.overflow)
                begin
                    state_next = ST_ERROR;
                end
                else if (!status.no_ones)
                begin
                    state_next = ST_ONES;
                end
                else if (!status.no_digits)
                begin
                    state_next = ST_DIGITS_RD;
                end
                else
                begin
                    state_next = ST_CLEAR;
                end
            end
            ST_ONES:
            begin
                if (status.out_free && status.ones_one)
                begin
                    state_next = status.no_digits ? ST_CLEAR : ST_DIGITS_RD;
                end
            end
            ST_DIGITS_RD:
            begin
                state_next = ST_DIGITS;
            end
            ST_DIGITS:
            begin
                if (status.out_free && status.digits_one)
                begin
                    state_next = ST_CLEAR;
                end
            end
            ST_ERROR:
            begin
                if (status.out_free)
                begin
                    state_next = ST_CLEAR;
                end
            end
            ST_CLEAR:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // commands
    always_comb
    begin
        cmd      = '0;
        in_stall = (state_reg != ST_IDLE);
        case (state_reg)
            ST_IDLE:
            begin
                cmd.take_item = in_valid;
            end
            ST_ABSORB:
            begin
                if (!status.overflow)
                begin
                    if (status.bytes_full)
                    begin
                        cmd.set_ovf = 1'b1;
                    end
                    else
                    begin
                        cmd.byte_inc = 1'b1;
                        if (status.lead_zero)
                        begin
                            cmd.set_ovf  = status.room_full;
                            cmd.ones_inc = !status.room_full;
                        end
                        else
                        begin
                            cmd.set_nz     = 1'b1;
                            cmd.walk_first = !status.no_digits;
                        end
                    end
                end
            end
            ST_WALK:
            begin
                cmd.walk_step = 1'b1;
            end
            ST_APPEND:
            begin
                if (!status.carry_zero)
                begin
                    if (status.room_full || status.digits_full)
                    begin
                        cmd.set_ovf = 1'b1;
                    end
                    else
                    begin
                        cmd.append = 1'b1;
                    end
                end
            end
            ST_ONES:
            begin
                cmd.emit_one = status.out_free;
            end
            ST_DIGITS:
            begin
                cmd.emit_digit = status.out_free;
            end
            ST_ERROR:
            begin
                cmd.emit_error = status.out_free;
            end
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    `B58_ASSERT_IMP(a_digits_nonempty, clk, rst_n,
        (state_reg == ST_DIGITS || state_reg == ST_WALK), !status.no_digits,
        "digit phase entered with an empty digit store")
    `B58_ASSERT_IMP(a_take_idle, clk, rst_n, cmd.take_item,
        $past(state_reg) != ST_ABSORB || state_reg == ST_IDLE,
        "item taken outside idle")
    `B58_ASSERT_IMP(a_walk_from_absorb, clk, rst_n,
        (state_reg == ST_WALK && $past(state_reg) != ST_WALK),
        $past(state_reg) == ST_ABSORB,
        "digit walk not started from absorb")

endmodule

>>> sv/b58enc_dpath.sv
// Datapath of the base58 encoder: message counters, digit store, carry
// divider and output register. Depends on b58enc_pkg, b58enc_ram and the defines.
`include "base58_encoder_defines.svh"

module b58enc_dpath
    import b58enc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_write_en,
    input  logic [CAP_W-1:0] cfg_write_data,
    input  in_item_t         in_item,
    output logic             out_valid,
    input  logic             out_stall,
    output out_item_t        out_item,
    input  cmd_t             cmd,
    output status_t          status
);

    logic [CAP_W-1:0]      cap_reg;
    logic [7:0]            carry_reg, carry_next;
    logic                  last_reg, last_next;
    logic [BYTE_CNT_W-1:0] byte_cnt_reg, byte_cnt_next;
    logic [CNT_W-1:0]      ones_reg, ones_next;
    logic [CNT_W-1:0]      dc_reg, dc_next;
    logic [ADDR_W-1:0]     idx_reg, idx_next;
    logic                  nz_reg, nz_next;
    logic                  ovf_reg, ovf_next;
    logic                  out_valid_reg, out_valid_next;
    out_item_t             out_item_reg, out_item_next;

    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr, ram_raddr;
    logic [DIGIT_W-1:0]    ram_wdata, ram_rdata;

    logic [CAP_W-1:0]      cap_eff;
    logic [CNT_W:0]        total;
    logic                  walk_end;
    logic                  out_free;

    logic [DIGIT_W-1:0]    hi;
    logic [Y_W-1:0]        y;
    logic [PROD_W-1:0]     prod;
    logic [QY_W-1:0]       qy_est;
    logic [Y_W-1:0]        r_est;
    logic [QY_W-1:0]       qy;
    logic [DIGIT_W-1:0]    rem;
    logic [QUOT_W-1:0]     quot;

    b58enc_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (MAX_DIGITS)
    ) u_digits (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // digit*256 + carry split as BASE*(HI_Q*digit) + y, then y divmod BASE
    always_comb
    begin
        hi     = cmd.walk_step ? ram_rdata : '0;
        y      = Y_W'(hi) * Y_W'(HI_MULT) + Y_W'(carry_reg);
        prod   = PROD_W'(y) * PROD_W'(RECIP);
        qy_est = QY_W'(prod >> RECIP_SH);
        r_est  = y - Y_W'(qy_est) * Y_W'(BASE);
        if (r_est >= Y_W'(BASE))
        begin
            rem = DIGIT_W'(r_est - Y_W'(BASE));
            qy  = qy_est + QY_W'(1);
        end
        else
        begin
            rem = DIGIT_W'(r_est);
            qy  = qy_est;
        end
        quot = QUOT_W'(hi) * QUOT_W'(HI_Q) + QUOT_W'(qy);
    end

    assign cap_eff  = (cap_reg > CAP_W'(MAX_DIGITS)) ? CAP_W'(MAX_DIGITS) : cap_reg;
    assign total    = {1'b0, ones_reg} + {1'b0, dc_reg};
    assign walk_end = (CNT_W'(idx_reg) + CNT_W'(1)) == dc_reg;
    assign out_free = !out_valid_reg || !out_stall;

    assign ram_we    = cmd.walk_step || cmd.append;
    assign ram_waddr = cmd.walk_step ? idx_reg : ADDR_W'(dc_reg);
    assign ram_wdata = rem;

    // read port: walk runs one digit ahead, emission reads from the top down
    always_comb
    begin
        if (cmd.walk_first)
        begin
            ram_raddr = '0;
        end
        else if (cmd.walk_step)
        begin
            ram_raddr = walk_end ? idx_reg : idx_reg + ADDR_W'(1);
        end
        else if (dc_reg == '0)
        begin
            ram_raddr = '0;
        end
        else if (cmd.emit_digit && dc_reg > CNT_W'(1))
        begin
            ram_raddr = ADDR_W'(dc_reg - CNT_W'(2));
        end
        else
        begin
            ram_raddr = ADDR_W'(dc_reg - CNT_W'(1));
        end
    end

    always_comb
    begin
        status.overflow    = ovf_reg;
        status.bytes_full  = byte_cnt_reg >= BYTE_CNT_W'(MAX_IN_BYTES);
        status.lead_zero   = !nz_reg && (carry_reg == '0);
        status.room_full   = CMP_W'(total) >= CMP_W'(cap_eff);
        status.digits_full = dc_reg >= CNT_W'(MAX_DIGITS);
        status.no_digits   = (dc_reg == '0);
        status.walk_end    = walk_end;
        status.carry_zero  = (carry_reg == '0);
        status.last        = last_reg;
        status.no_ones     = (ones_reg == '0);
        status.ones_one    = (ones_reg == CNT_W'(1));
        status.digits_one  = (dc_reg == CNT_W'(1));
        status.out_free    = out_free;
    end

    always_comb
    begin
        carry_next     = carry_reg;
        last_next      = last_reg;
        byte_cnt_next  = byte_cnt_reg;
        ones_next      = ones_reg;
        dc_next        = dc_reg;
        idx_next       = idx_reg;
        nz_next        = nz_reg;
        ovf_next       = ovf_reg;
        out_item_next  = out_item_reg;
        out_valid_next = out_valid_reg && out_stall;

        if (cmd.take_item)
        begin
            carry_next = in_item.data_byte;
            last_next  = in_item.last_byte;
        end
        if (cmd.byte_inc)
        begin
            byte_cnt_next = byte_cnt_reg + BYTE_CNT_W'(1);
        end
        if (cmd.set_ovf)
        begin
            ovf_next = 1'b1;
        end
        if (cmd.set_nz)
        begin
            nz_next = 1'b1;
        end
        if (cmd.ones_inc)
        begin
            ones_next = ones_reg + CNT_W'(1);
        end
        if (cmd.walk_first)
        begin
            idx_next = '0;
        end
        if (cmd.walk_step)
        begin
            carry_next = quot;
            if (!walk_end)
            begin
                idx_next = idx_reg + ADDR_W'(1);
            end
        end
        if (cmd.append)
        begin
            carry_next = quot;
            dc_next    = dc_reg + CNT_W'(1);
        end
        if (cmd.emit_one)
        begin
            out_valid_next              = 1'b1;
            out_item_next.out_char      = ONE_CHAR;
            out_item_next.last_char     = (ones_reg == CNT_W'(1)) && (dc_reg == '0);
            out_item_next.encode_error  = 1'b0;
            ones_next                   = ones_reg - CNT_W'(1);
        end
        if (cmd.emit_digit)
        begin
            out_valid_next              = 1'b1;
            out_item_next.out_char      = b58_char(ram_rdata);
            out_item_next.last_char     = (dc_reg == CNT_W'(1));
            out_item_next.encode_error  = 1'b0;
            dc_next                     = dc_reg - CNT_W'(1);
        end
        if (cmd.emit_error)
        begin
            out_valid_next              = 1'b1;
            out_item_next.out_char      = '0;
            out_item_next.last_char     = 1'b0;
            out_item_next.encode_error  = 1'b1;
        end
        if (cmd.clear)
        begin
            byte_cnt_next = '0;
            ones_next     = '0;
            dc_next       = '0;
            nz_next       = 1'b0;
            ovf_next      = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CAP_W'(CAP_RESET);
            byte_cnt_reg  <= '0;
            ones_reg      <= '0;
            dc_reg        <= '0;
            nz_reg        <= 1'b0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                cap_reg <= cfg_write_data;
            end
            byte_cnt_reg  <= byte_cnt_next;
            ones_reg      <= ones_next;
            dc_reg        <= dc_next;
            nz_reg        <= nz_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        carry_reg    <= carry_next;
        last_reg     <= last_next;
        idx_reg      <= idx_next;
        out_item_reg <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    `B58_ASSERT(a_dc_bound, clk, rst_n, dc_reg <= CNT_W'(MAX_DIGITS),
        "digit count above store depth")
    `B58_ASSERT_IMP(a_load_free, clk, rst_n,
        (cmd.emit_one || cmd.emit_digit || cmd.emit_error), out_free,
        "output register loaded while still holding an unaccepted item")
    `B58_ASSERT_IMP(a_err_item, clk, rst_n, (out_valid_reg && out_item_reg.encode_error),
        (out_item_reg.out_char == '0) && !out_item_reg.last_char,
        "error item carries a character")
    `B58_ASSERT_IMP(a_wr_range, clk, rst_n, ram_we,
        CNT_W'(ram_waddr) < CNT_W'(MAX_DIGITS),
        "digit write beyond store depth")

endmodule

>>> sv/base58_encoder.sv
// Base58 encoder (Bitcoin alphabet), top level.
// Depends on b58enc_pkg, b58enc_ctrl, b58enc_dpath (with b58enc_ram).
//
// Use:
//   in channel  (in_valid/in_stall/in_item): one message byte per item,
//     most significant first, last_byte set on the final byte.
//   out channel (out_valid/out_stall/out_item): one ASCII character per item,
//     '1' per leading zero byte, then base58 digits most significant first;
//     last_char marks the final one. On a limit violation a single item with
//     encode_error set (char 0, last_char 0) replaces the characters.
//   cfg_write_en/cfg_write_data: out_capacity, write only when idle.
// Sequence:
//   Each byte is taken in idle, absorbed, then multiplied by 256 in a walk
//   over every stored digit in the digit RAM; up to two appends plus one check
//   follow, then finish and back to idle, which takes the next item. Leading
//   zero bytes and bytes after an overflow go from absorb to finish directly.
//   After the final byte, characters are loaded one per cycle while the output
//   register is free: the '1's, a RAM read state, then the digits; a clear
//   state and the idle state follow.
// Reset: asynchronous, active low; message state cleared, out_capacity = 64.
// Stall: the output register holds its item while out_stall is high; the
//   sequencer waits and in_stall stays high until it is back in idle.
module base58_encoder
    import b58enc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_write_en,
    input  logic [CAP_W-1:0] cfg_write_data,
    input  logic             in_valid,
    output logic             in_stall,
    input  in_item_t         in_item,
    output logic             out_valid,
    input  logic             out_stall,
    output out_item_t        out_item
);

    cmd_t    cmd;
    status_t status;

    // sequencer: owns the in-channel handshake
    b58enc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // counters, digit store, divider and output register
    b58enc_dpath u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_item        (in_item),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_item       (out_item),
        .cmd            (cmd),
        .status         (status)
    );

endmodule
